// ----- hdl/ufcs_pkg.sv -----
// Shared types and byte constants for the UTF-8 format-control stripper.
`default_nettype none

package ufcs_pkg;

    // ASCII bytes
    localparam logic [7:0] ASCII_CTRL_MAX = 8'h1F;
    localparam logic [7:0] ASCII_TAB      = 8'h09;
    localparam logic [7:0] ASCII_LF       = 8'h0A;
    localparam logic [7:0] ASCII_DEL      = 8'h7F;
    localparam logic [7:0] ASCII_TOP      = 8'h80;

    // Lead bytes of the sequences that get dropped
    localparam logic [7:0] LEAD_C2 = 8'hC2;
    localparam logic [7:0] LEAD_D8 = 8'hD8;
    localparam logic [7:0] LEAD_E2 = 8'hE2;
    localparam logic [7:0] LEAD_EF = 8'hEF;

    // C2 tails: C1 controls and soft hyphen
    localparam logic [7:0] C1_LO    = 8'h80;
    localparam logic [7:0] C1_HI    = 8'h9F;
    localparam logic [7:0] SOFT_HYP = 8'hAD;

    // D8 tail: Arabic letter mark
    localparam logic [7:0] ALM_TAIL = 8'h9C;

    // E2 middle bytes and their tail ranges
    localparam logic [7:0] E2_MID_80 = 8'h80;
    localparam logic [7:0] E2_MID_81 = 8'h81;
    localparam logic [7:0] ZW_LO     = 8'h8B;
    localparam logic [7:0] ZW_HI     = 8'h8F;
    localparam logic [7:0] BIDI_LO   = 8'hAA;
    localparam logic [7:0] BIDI_HI   = 8'hAE;
    localparam logic [7:0] WJ_LO     = 8'hA0;
    localparam logic [7:0] WJ_HI     = 8'hA4;
    localparam logic [7:0] ISO_LO    = 8'hA6;
    localparam logic [7:0] ISO_HI    = 8'hA9;

    // Byte order mark tail
    localparam logic [7:0] BOM_MID  = 8'hBB;
    localparam logic [7:0] BOM_TAIL = 8'hBF;

    // Results per input word and result queue size
    localparam int MAX_RES  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);
    localparam int RES_CW   = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] item;
        logic [RES_CW-1:0]  num;
    } res_bundle_t;

endpackage

`default_nettype wire

// ----- hdl/ufcs_window.sv -----
// Pending-prefix state and the match/emit decision over a window of up to three bytes.
`default_nettype none

module ufcs_window (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 end_of_text,
    output ufcs_pkg::res_bundle_t     res
);
    import ufcs_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [7:0] pend_reg [2];
    logic [7:0] pend_next [2];

    logic [7:0] w [5];
    logic [2:0] n;
    logic [2:0] pos;
    logic [2:0] rem;
    logic       hold;
    logic [1:0] nk;
    logic [7:0] kept [MAX_RES];
    logic [7:0] b;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       emit;
    logic [1:0] drop;
    logic       m;

    always_comb
    begin
        w[0] = 8'h00;
        w[1] = 8'h00;
        w[2] = 8'h00;
        w[3] = 8'h00;
        w[4] = 8'h00;
        unique case (cnt_reg)
            2'd0:
            begin
                w[0] = in_byte;
            end
            2'd1:
            begin
                w[0] = pend_reg[0];
                w[1] = in_byte;
            end
            default:
            begin
                w[0] = pend_reg[0];
                w[1] = pend_reg[1];
                w[2] = in_byte;
            end
        endcase
        n = (cnt_reg == 2'd3) ? 3'd3 : {1'b0, cnt_reg} + 3'd1;

        pos     = 3'd0;
        hold    = 1'b0;
        nk      = 2'd0;
        kept[0] = 8'h00;
        kept[1] = 8'h00;
        kept[2] = 8'h00;
        b = 8'h00;
        b1 = 8'h00;
        b2 = 8'h00;
        rem = 3'd0;
        emit = 1'b0;
        drop = 2'd0;
        m = 1'b0;

        // At most three decisions: each one consumes one or more bytes or holds.
        for (int it = 0; it < MAX_RES; it++)
        begin
            if (pos < n && !hold)
            begin
                b    = w[pos];
                b1   = w[pos + 3'd1];
                b2   = w[pos + 3'd2];
                rem  = n - pos - 3'd1;
                emit = 1'b0;
                drop = 2'd0;
                m    = 1'b0;
                if (b < ASCII_TOP)
                begin
                    if ((b <= ASCII_CTRL_MAX && b != ASCII_TAB && b != ASCII_LF)
                        || b == ASCII_DEL)
                        drop = 2'd1;
                    else
                        emit = 1'b1;
                end
                else if (b == LEAD_C2 || b == LEAD_D8)
                begin
                    if (rem == 3'd0)
                    begin
                        if (end_of_text)
                            emit = 1'b1;
                        else
                            hold = 1'b1;
                    end
                    else
                    begin
                        m = (b == LEAD_C2)
                            ? ((b1 >= C1_LO && b1 <= C1_HI) || b1 == SOFT_HYP)
                            : (b1 == ALM_TAIL);
                        if (m)
                            drop = 2'd2;
                        else
                            emit = 1'b1;
                    end
                end
                else if (b == LEAD_E2 || b == LEAD_EF)
                begin
                    m = (b == LEAD_E2) ? (b1 == E2_MID_80 || b1 == E2_MID_81)
                                       : (b1 == BOM_MID);
                    if (rem == 3'd0)
                    begin
                        if (end_of_text)
                            emit = 1'b1;
                        else
                            hold = 1'b1;
                    end
                    else if (!m)
                    begin
                        emit = 1'b1;
                    end
                    else if (rem == 3'd1)
                    begin
                        if (end_of_text)
                            emit = 1'b1;
                        else
                            hold = 1'b1;
                    end
                    else
                    begin
                        if (b == LEAD_EF)
                            m = (b2 == BOM_TAIL);
                        else if (b1 == E2_MID_80)
                            m = (b2 >= ZW_LO && b2 <= ZW_HI)
                                || (b2 >= BIDI_LO && b2 <= BIDI_HI);
                        else
                            m = (b2 >= WJ_LO && b2 <= WJ_HI)
                                || (b2 >= ISO_LO && b2 <= ISO_HI);
                        if (m)
                            drop = 2'd3;
                        else
                            emit = 1'b1;
                    end
                end
                else
                begin
                    emit = 1'b1;
                end

                if (emit)
                begin
                    kept[nk] = b;
                    nk       = nk + 2'd1;
                    pos      = pos + 3'd1;
                end
                else if (!hold)
                begin
                    pos = pos + {1'b0, drop};
                end
            end
        end

        // Hold the unresolved tail of the window for the next word.
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        cnt_next     = cnt_reg;
        if (step)
        begin
            cnt_next = 2'd0;
            if (hold)
            begin
                pend_next[0] = w[pos];
                pend_next[1] = w[pos + 3'd1];
                cnt_next     = 2'(n - pos);
            end
        end

        for (int k = 0; k < MAX_RES; k++)
        begin
            res.item[k].data = kept[k];
            res.item[k].has  = 1'b1;
            res.item[k].last = end_of_text && (k == int'(nk) - 1);
        end
        res.num = nk;
        if (end_of_text && nk == 2'd0)
        begin
            res.item[0].data = 8'h00;
            res.item[0].has  = 1'b0;
            res.item[0].last = 1'b1;
            res.num          = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("pending count above two");

    a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> cnt_reg == 2'd0)
        else $error("bytes still pending after end of text");

    a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |-> res.num != 2'd0)
        else $error("end of text produced no result");

endmodule

`default_nettype wire

// ----- hdl/ufcs_out_queue.sv -----
// Result queue: takes up to three results per cycle, pops one per ready cycle.
`default_nettype none

module ufcs_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ufcs_pkg::res_bundle_t res,
    output logic                      space,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);
    import ufcs_pkg::*;

    res_t             mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_next;
    logic [Q_CW-1:0]  count_reg;
    logic [Q_CW-1:0]  count_next;
    logic [Q_CW-1:0]  push_n;
    logic             pop;
    res_t             head;

    assign push_n   = push ? Q_CW'(res.num) : '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = mem_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.data;
    assign m_tuser  = head.has;
    assign m_tlast  = head.last;
    // Room for a full burst whatever the output side does this cycle.
    assign space    = (count_reg <= Q_CW'(Q_DEPTH - MAX_RES));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + (pop ? Q_AW'(1) : Q_AW'(0));
        count_next  = count_reg + push_n - (pop ? Q_CW'(1) : Q_CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (Q_CW'(k) < push_n)
                mem_reg[wr_ptr_reg + Q_AW'(k)] <= res.item[k];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ({1'b0, count_reg} + {1'b0, push_n}) <= (Q_CW + 1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_n == '0 |=> count_reg == $past(count_reg) - Q_CW'(1))
        else $error("queue count did not drop on pop");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/utf8_format_control_stripper_top.sv -----
// Top level of the UTF-8 format-control stripper: input register, decision stage, result queue.
//
// Strips ASCII controls (except tab and line feed), DEL, C1 controls, soft hyphen, the Arabic
// letter mark, zero-width marks, bidi overrides and isolates, word joiners and the BOM from a
// UTF-8 byte stream. One byte word enters per cycle on s_axis while s_tready is high; tlast
// marks the final byte of a text. Each accepted word passes an input register, then
// combinational decision logic over the up to two held prefix bytes plus the new byte, and
// lands in a four-entry result queue that feeds m_axis. Sustained rate is one word per cycle
// while m_tready stays high. A word that releases two or three results at once (a failed
// prefix, or a flush at end of text) raises the queue above one entry, and intake pauses
// until the queue is back down to one entry. m_tuser low with m_tlast high is a bare end
// marker with no byte.
`default_nettype none

module utf8_format_control_stripper_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tuser,    // [0] has_byte
    output logic            m_tlast     // last
);
    import ufcs_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;
    logic        space;
    logic        step;
    logic        load;
    res_bundle_t res;

    assign step     = in_valid_reg && space;
    assign s_tready = !in_valid_reg || step;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    ufcs_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .in_byte     (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res         (res)
    );

    ufcs_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
